[rtl/core/rss_pkg.sv]
package rss_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_PATTERN_DEF = 8;
    localparam int INDEX_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int PBYTES_W = 64;
    localparam int PLEN_W   = 4;
    localparam int POS_W    = 16;
    localparam int CIDX_W   = 3;
    localparam int PLANES   = PBYTES_W / BYTE_W;
    localparam int LANE_CNT = 1 << PLEN_W;

    typedef enum logic [1:0] {
        STATUS_SEARCHED = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PATTERN_BYTES  = 3'd0,
        CFG_PATTERN_LENGTH = 3'd1,
        CFG_RANGE_START    = 3'd2,
        CFG_RANGE_LENGTH   = 3'd3,
        CFG_RANGE_TO_END   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [PBYTES_W-1:0] pattern_bytes;
        logic [PLEN_W-1:0]   pattern_length;
        logic [POS_W-1:0]    range_start;
        logic [POS_W-1:0]    range_length;
        logic                range_to_end;
    } cfg_t;

    // Pattern byte at a lane; lanes past the stored word read as zero.
    function automatic logic [BYTE_W-1:0] pattern_lane(
        input logic [PBYTES_W-1:0] pattern,
        input logic [PLEN_W-1:0]   lane
    );
        logic [BYTE_W-1:0] lanes [LANE_CNT];
        for (int k = 0; k < LANE_CNT; k++) begin
            lanes[k] = '0;
        end
        for (int k = 0; k < PLANES; k++) begin
            lanes[k] = pattern[k*BYTE_W +: BYTE_W];
        end
        return lanes[lane];
    endfunction

endpackage

[rtl/core/ranged_substring_search.sv]
// Result path: the input register takes the beat that ends the text, and the
// result register is loaded from it once that beat leaves the input register,
// which raises m_valid.
// Throughput: one text beat per cycle; a closing beat waits only while an
// earlier result is still held and not taken.
// Reset: aresetn is synchronous and active low; it empties the pipeline, clears
// the window, byte count and match tracking, and loads register defaults.
module ranged_substring_search #(
    parameter int MAX_PATTERN = rss_pkg::MAX_PATTERN_DEF,
    parameter int INDEX_WIDTH = rss_pkg::INDEX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rss_pkg::BYTE_W-1:0]   s_text_byte,
    input  logic                         s_carries_byte,
    input  logic                         s_last_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [rss_pkg::POS_W-1:0]    m_match_position,
    output logic [1:0]                   m_search_status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rss_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [63:0]                  cfg_data
);
    import rss_pkg::*;

    // Width for index arithmetic: holds the saturated count, a 16-bit range
    // sum, and a carry.
    localparam int SW = ((INDEX_WIDTH > POS_W) ? INDEX_WIDTH : POS_W) + 2;

    cfg_t cfg;

    // Configuration writes are always taken; the user must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    rss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register. A beat that ends the text may only leave it when the
    // result register is free or being drained in the same cycle.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_carries_reg;
    logic              in_last_reg;
    logic              out_free;
    logic              advance;
    logic              take;
    logic              finish;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign take     = advance && in_carries_reg;
    assign finish   = advance && in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg    <= s_text_byte;
            in_carries_reg <= s_carries_byte;
            in_last_reg    <= s_last_byte;
        end
    end

    // Shift window and pattern compare for the byte now being taken.
    logic hit;

    rss_window_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .shift_en       (take),
        .clear          (finish),
        .text_byte      (in_byte_reg),
        .pattern_bytes  (cfg.pattern_bytes),
        .pattern_length (cfg.pattern_length),
        .hit            (hit)
    );

    // Byte count saturates at 2^INDEX_WIDTH, which marks a text that is too
    // long. Only the first match that fits the range is kept.
    logic [INDEX_WIDTH:0]   bytes_seen_reg, bytes_seen_next;
    logic                   match_seen_reg, match_seen_next;
    logic [INDEX_WIDTH-1:0] first_position_reg, first_position_next;
    logic [INDEX_WIDTH:0]   count_inc;
    logic [SW-1:0]          start_pos;
    logic                   plen_over;
    logic                   check;
    logic                   hit_now;

    assign count_inc = bytes_seen_reg + 1'b1;
    assign start_pos = SW'(count_inc) - SW'(cfg.pattern_length);
    assign plen_over = {4'b0000, cfg.pattern_length} > 8'(MAX_PATTERN);

    always_comb begin
        check = take && !bytes_seen_reg[INDEX_WIDTH] && !count_inc[INDEX_WIDTH]
              && !match_seen_reg && (cfg.pattern_length != '0) && !plen_over
              && (SW'(count_inc) >= SW'(cfg.pattern_length))
              && (start_pos >= SW'(cfg.range_start))
              && (cfg.range_to_end
                  || SW'(count_inc) <= SW'(cfg.range_start) + SW'(cfg.range_length));
        hit_now = check && hit;

        bytes_seen_next     = (take && !bytes_seen_reg[INDEX_WIDTH]) ? count_inc
                                                                     : bytes_seen_reg;
        match_seen_next     = match_seen_reg || hit_now;
        first_position_next = hit_now ? start_pos[INDEX_WIDTH-1:0] : first_position_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || finish) begin
            bytes_seen_reg     <= '0;
            match_seen_reg     <= 1'b0;
            first_position_reg <= '0;
        end else begin
            bytes_seen_reg     <= bytes_seen_next;
            match_seen_reg     <= match_seen_next;
            first_position_reg <= first_position_next;
        end
    end

    // Final checks, made against the count that includes the last byte.
    logic [SW-1:0] text_len;
    logic [SW-1:0] range_eff;
    logic          found_next;
    logic [POS_W-1:0] pos_next;
    status_t       status_next;

    always_comb begin
        text_len    = SW'(bytes_seen_next);
        range_eff   = cfg.range_to_end ? text_len - SW'(cfg.range_start)
                                       : SW'(cfg.range_length);
        found_next  = 1'b0;
        pos_next    = '0;
        status_next = STATUS_SEARCHED;
        if (bytes_seen_next[INDEX_WIDTH]) begin
            status_next = STATUS_TOO_LONG;
        end else if (plen_over || SW'(cfg.range_start) > text_len) begin
            status_next = STATUS_INVALID;
        end else if (SW'(cfg.range_start) + range_eff > text_len
                     || SW'(cfg.pattern_length) > range_eff) begin
            status_next = STATUS_INVALID;
        end else if (cfg.pattern_length == '0) begin
            found_next = 1'b1;
            pos_next   = cfg.range_start;
        end else if (match_seen_next) begin
            found_next = 1'b1;
            pos_next   = POS_W'(SW'(first_position_next));
        end
    end

    // Result register: loaded only when it is free or drains this cycle.
    logic             m_valid_reg;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;
    status_t          status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found          = found_reg;
    assign m_match_position = pos_reg;
    assign m_search_status  = status_reg;

endmodule

[rtl/core/rss_cfg_regs.sv]
module rss_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [rss_pkg::CIDX_W-1:0] wr_index,
    input  logic [63:0]                wr_data,
    output rss_pkg::cfg_t              cfg
);
    import rss_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_PATTERN_BYTES:  cfg_next.pattern_bytes  = wr_data[PBYTES_W-1:0];
                CFG_PATTERN_LENGTH: cfg_next.pattern_length = wr_data[PLEN_W-1:0];
                CFG_RANGE_START:    cfg_next.range_start    = wr_data[POS_W-1:0];
                CFG_RANGE_LENGTH:   cfg_next.range_length   = wr_data[POS_W-1:0];
                CFG_RANGE_TO_END:   cfg_next.range_to_end   = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{pattern_bytes: '0, pattern_length: '0, range_start: '0,
                         range_length: '0, range_to_end: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/rss_window_match.sv]
module rss_window_match #(
    parameter int MAX_PATTERN = rss_pkg::MAX_PATTERN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         shift_en,
    input  logic                         clear,
    input  logic [rss_pkg::BYTE_W-1:0]   text_byte,
    input  logic [rss_pkg::PBYTES_W-1:0] pattern_bytes,
    input  logic [rss_pkg::PLEN_W-1:0]   pattern_length,
    output logic                         hit
);
    import rss_pkg::*;

    // Entry 0 holds the newest byte.
    logic [BYTE_W-1:0] window_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] shifted    [MAX_PATTERN];

    always_comb begin
        shifted[0] = text_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            shifted[k] = window_reg[k-1];
        end
    end

    // Window entry i lines up with pattern lane (length - 1 - i).
    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (7'(i) < {3'b000, pattern_length}) begin
                if (shifted[i] != pattern_lane(pattern_bytes,
                                               pattern_length - PLEN_W'(i) - 4'd1)) begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                window_reg[k] <= '0;
            end
        end else if (shift_en) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                window_reg[k] <= shifted[k];
            end
        end
    end

endmodule

[rtl/core/rss_checker.sv]
module rss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [15:0] m_match_position,
    input logic [1:0]  m_search_status
);
    import rss_pkg::*;

    // A pending result beat is held until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped before it was taken");

    // A match is only reported from a completed search.
    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_search_status == STATUS_SEARCHED)
        else $error("match reported with a failure status");

    // Without a match the position reads zero.
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_position == '0)
        else $error("position nonzero without a match");

    // No status code beyond the defined ones.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_search_status != 2'd3)
        else $error("undefined status code");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ranged_substring_search rss_checker u_rss_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_found          (m_found),
    .m_match_position (m_match_position),
    .m_search_status  (m_search_status)
);

[bench/ranged_substring_search_tb.sv]
`timescale 1ns / 1ps

module ranged_substring_search_tb;
    import rss_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int TEXT_LIMIT      = (1 << INDEX_WIDTH_DEF) - 1;
    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam int IDLE_PCT        = 13;
    // The result register sits behind the input register that takes the closing
    // beat; this quiet spell follows the last result before the registers change.
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int STRESS_PHASE    = 3;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int CYCLE_LIMIT     = 2_000_000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                carries;
        bit                ends_text;
    } text_beat_t;

    typedef struct {
        bit               found;
        logic [POS_W-1:0] position;
        status_t          status;
    } search_verdict_t;

    // Everything the bench drives starts at a known value.
    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_text_byte     = '0;
    logic                s_carries_byte  = 1'b0;
    logic                s_last_byte     = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_found;
    logic [POS_W-1:0]    m_match_position;
    logic [1:0]          m_search_status;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index       = '0;
    logic [63:0]         cfg_data        = '0;

    ranged_substring_search u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_carries_byte   (s_carries_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_match_position (m_match_position),
        .m_search_status  (m_search_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Our own copy of the search registers, updated on every accepted write beat.
    logic [PBYTES_W-1:0] pat_cfg    = '0;
    logic [PLEN_W-1:0]   plen_cfg   = '0;
    logic [POS_W-1:0]    start_cfg  = '0;
    logic [POS_W-1:0]    span_cfg   = '0;
    bit                  to_end_cfg = 1'b1;

    // Per-text tracking: the most recent bytes (index 0 newest), how many bytes
    // the text has had so far, and the earliest in-range hit.
    logic [BYTE_W-1:0]   recent_bytes [MAX_PATTERN_DEF];
    int                  seen_count;
    bit                  match_pending;
    int                  first_hit;

    text_beat_t          beats_pending [$];
    search_verdict_t     verdicts_due [$];

    int  fail_count    = 0;
    int  texts_queued  = 0;
    int  items_queued  = 0;
    int  writes_done   = 0;
    int  found_seen    = 0;
    int  invalid_seen  = 0;
    int  too_long_seen = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    bit  quiet_mode    = 1'b0;
    bit  long_stall_due = 1'b0;
    bit  s_beat_taken  = 1'b0;

    function automatic void clear_text_state();
        foreach (recent_bytes[k]) recent_bytes[k] = '0;
        seen_count    = 0;
        match_pending = 1'b0;
        first_hit     = 0;
    endfunction

    // Shifts one byte into the window and checks whether the pattern now ends
    // on it and lies inside the search range.
    function automatic void slide_in_byte(input logic [BYTE_W-1:0] b);
        int n;
        int s;
        int plen;
        bit same;
        plen = int'(plen_cfg);
        for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) begin
            recent_bytes[k] = recent_bytes[k-1];
        end
        recent_bytes[0] = b;
        // The count stops one past the limit, so an overlong text stays flagged.
        if (seen_count > TEXT_LIMIT) return;
        n = seen_count;
        seen_count++;
        if (seen_count > TEXT_LIMIT) return;
        if (match_pending || plen == 0 || plen > MAX_PATTERN_DEF || n + 1 < plen) return;
        s = n + 1 - plen;
        if (s < int'(start_cfg)) return;
        if (!to_end_cfg && s + plen > int'(start_cfg) + int'(span_cfg)) return;
        same = 1'b1;
        for (int i = 0; i < plen; i++) begin
            if (recent_bytes[plen-1-i] != pat_cfg[i*BYTE_W +: BYTE_W]) same = 1'b0;
        end
        if (same) begin
            match_pending = 1'b1;
            first_hit     = s;
        end
    endfunction

    // Range validity checks happen only once the text length is known.
    function automatic search_verdict_t close_text();
        search_verdict_t v;
        int len;
        int rs;
        int rl;
        int plen;
        v.found    = 1'b0;
        v.position = '0;
        v.status   = STATUS_SEARCHED;
        len  = seen_count;
        rs   = int'(start_cfg);
        plen = int'(plen_cfg);
        if (len > TEXT_LIMIT) begin
            v.status = STATUS_TOO_LONG;
        end else if (plen > MAX_PATTERN_DEF || rs > len) begin
            v.status = STATUS_INVALID;
        end else begin
            rl = to_end_cfg ? len - rs : int'(span_cfg);
            if (rs + rl > len || plen > rl) begin
                v.status = STATUS_INVALID;
            end else if (plen == 0) begin
                // An empty pattern sits at the start of any valid range.
                v.found    = 1'b1;
                v.position = start_cfg;
            end else if (match_pending) begin
                v.found    = 1'b1;
                v.position = POS_W'(first_hit);
            end
        end
        clear_text_state();
        return v;
    endfunction

    function automatic void apply_register(input logic [CIDX_W-1:0] idx,
                                           input logic [63:0] data);
        case (idx)
            CFG_PATTERN_BYTES:  pat_cfg    = data;
            CFG_PATTERN_LENGTH: plen_cfg   = data[PLEN_W-1:0];
            CFG_RANGE_START:    start_cfg  = data[POS_W-1:0];
            CFG_RANGE_LENGTH:   span_cfg   = data[POS_W-1:0];
            CFG_RANGE_TO_END:   to_end_cfg = data[0];
            default: ;
        endcase
    endfunction

    // Input side: every accepted beat feeds the prediction, and every accepted
    // register write updates our copy of the registers.
    always @(posedge aclk) begin
        s_beat_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (s_carries_byte) slide_in_byte(s_text_byte);
            if (s_last_byte) verdicts_due.push_back(close_text());
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            apply_register(cfg_index, cfg_data);
            writes_done++;
        end
    end

    // Driver: a new beat goes out at the falling edge only once the previous
    // one was taken, so valid and payload hold steady while the block stalls.
    always @(negedge aclk) begin
        text_beat_t nxt;
        if (aresetn && (!s_valid || s_beat_taken)) begin
            if (beats_pending.size() != 0 &&
                (quiet_mode || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = beats_pending.pop_front();
                s_valid        <= 1'b1;
                s_text_byte    <= nxt.data;
                s_carries_byte <= nxt.carries;
                s_last_byte    <= nxt.ends_text;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, none in quiet mode, and on request one long
    // hold-off so results back up and the block has to stop taking text.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (long_stall_due) begin
            long_stall_due <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            m_ready        <= 1'b0;
        end else begin
            m_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result monitor: each result beat is held against the oldest prediction.
    always @(posedge aclk) begin
        search_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result beat with no text outstanding: found %0d position %0d status %0d",
                       m_found, m_match_position, m_search_status);
                fail_count++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_found);
                    fail_count++;
                end
                if (m_match_position !== want.position) begin
                    $error("match_position: expected %0d, actual %0d",
                           want.position, m_match_position);
                    fail_count++;
                end
                if (m_search_status !== want.status) begin
                    $error("search_status: expected %0d, actual %0d",
                           want.status, m_search_status);
                    fail_count++;
                end
                if (want.found) found_seen++;
                if (want.status == STATUS_INVALID) invalid_seen++;
                if (want.status == STATUS_TOO_LONG) too_long_seen++;
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, verdicts_due.size());
            $display("ranged_substring_search: mismatch");
            $finish;
        end
    end

    task automatic push_beat(input logic [BYTE_W-1:0] b, input bit carries, input bit ends);
        text_beat_t t;
        t.data      = b;
        t.carries   = carries;
        t.ends_text = ends;
        beats_pending.push_back(t);
        if (carries || ends) items_queued++;
    endtask

    // Queues a text given as packed bytes, first byte in the lowest lane.
    task automatic queue_packed(input logic [8*BYTE_W-1+BYTE_W:0] bytes, input int count);
        for (int k = 0; k < count; k++) begin
            push_beat(bytes[k*BYTE_W +: BYTE_W], 1'b1, k == count - 1);
        end
        texts_queued++;
    endtask

    // Queues a text of random content. Narrow texts draw their bytes from the
    // pattern lanes so partial and full matches turn up often; a copy of the
    // pattern is planted at embed_at when it fits. Some ignored beats are
    // sprinkled in, and now and then the text is closed by a beat that carries
    // no byte.
    task automatic queue_text(input int len, input int embed_at, input bit wide);
        logic [BYTE_W-1:0] body [$];
        int plen;
        int lane;
        bit bare_end;
        plen = int'(plen_cfg);
        for (int k = 0; k < len; k++) begin
            lane = $urandom_range(PLANES - 1);
            body.push_back(wide ? BYTE_W'($urandom_range(255)) : pat_cfg[lane*BYTE_W +: BYTE_W]);
        end
        if (embed_at >= 0 && plen >= 1 && plen <= MAX_PATTERN_DEF && embed_at + plen <= len) begin
            for (int i = 0; i < plen; i++) begin
                body[embed_at+i] = pat_cfg[i*BYTE_W +: BYTE_W];
            end
        end
        bare_end = len > 0 && $urandom_range(29) == 0;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(19) == 0) push_beat(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
            push_beat(body[k], 1'b1, k == len - 1 && !bare_end);
        end
        if (len == 0 || bare_end) push_beat(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
        texts_queued++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all five registers, with random junk above each field so every
    // data bit toggles, plus one write to an unused index that must be ignored.
    task automatic write_search_setup(input logic [63:0] pattern, input int plen,
                                      input int rs, input int rl, input bit to_end);
        logic [63:0] junk;
        write_reg(CFG_PATTERN_BYTES, pattern);
        junk = {$urandom, $urandom};
        junk[PLEN_W-1:0] = PLEN_W'(plen);
        write_reg(CFG_PATTERN_LENGTH, junk);
        junk = {$urandom, $urandom};
        junk[POS_W-1:0] = POS_W'(rs);
        write_reg(CFG_RANGE_START, junk);
        junk = {$urandom, $urandom};
        junk[POS_W-1:0] = POS_W'(rl);
        write_reg(CFG_RANGE_LENGTH, junk);
        junk = {$urandom, $urandom};
        junk[0] = to_end;
        write_reg(CFG_RANGE_TO_END, junk);
        write_reg(CIDX_W'($urandom_range((1 << CIDX_W) - 1, int'(CFG_RANGE_TO_END) + 1)),
                  {$urandom, $urandom});
    endtask

    // Lets everything queued drain and every result arrive before the
    // registers may change again.
    task automatic finish_phase();
        while (beats_pending.size() != 0 || s_valid || verdicts_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [63:0] pattern;
        int          plen;
        int          rs;
        int          rl;
        int          r;
        int          len;
        int          goal;
        clear_text_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset registers: empty pattern, range from zero to the end. An
        // ignored beat, an empty text, and a two-byte text at the byte extremes.
        push_beat(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
        push_beat(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'hff, 1'b1, 1'b1);
        finish_phase();

        // Three-byte pattern, range of six bytes from index two. The first text
        // has a hit before the range and another one inside it; the second has
        // its only hit straddling the end of the range; the third is shorter
        // than the range start.
        write_search_setup(64'h0000_0000_00ff_0011, 3, 2, 6, 1'b0);
        queue_packed(72'h00_0000_ff00_11ff_0011, 8);
        queue_packed(72'hff_0011_0000_0000_0000, 9);
        queue_packed(72'h11, 1);
        finish_phase();

        // Random phases. One of them runs without idling on the sender while
        // the receiver holds off for a long stretch.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(7))
                0:       pattern = '1;
                1:       pattern = '0;
                default: pattern = {$urandom, $urandom};
            endcase
            r = $urandom_range(9);
            if (r == 0)      plen = 0;
            else if (r == 1) plen = $urandom_range((1 << PLEN_W) - 1, MAX_PATTERN_DEF + 1);
            else if (r == 2) plen = MAX_PATTERN_DEF;
            else             plen = $urandom_range(MAX_PATTERN_DEF, 1);
            r = $urandom_range(9);
            if (r == 0)      rs = POS_MAX;
            else if (r == 1) rs = $urandom_range(POS_MAX);
            else             rs = $urandom_range(6);
            r = $urandom_range(9);
            if (r == 0)      rl = POS_MAX;
            else if (r == 1) rl = $urandom_range(POS_MAX);
            else             rl = $urandom_range(24);
            write_search_setup(pattern, plen, rs, rl, $urandom_range(1));

            quiet_mode     = (ph == STRESS_PHASE);
            long_stall_due = quiet_mode;
            goal = items_queued + ITEMS_PER_PHASE;
            while (items_queued < goal) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
                queue_text(len, ($urandom_range(9) < 6) ? $urandom_range(len) : -1,
                           $urandom_range(1));
            end
            finish_phase();
        end
        quiet_mode = 1'b0;

        $display("run covered %0d texts in %0d beats and %0d register writes",
                 texts_queued, items_queued, writes_done);
        $display("results: %0d with a match, %0d rejected range or pattern, %0d over length",
                 found_seen, invalid_seen, too_long_seen);
        if (fail_count == 0) begin
            $display("ranged_substring_search: match");
        end else begin
            $display("ranged_substring_search: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/rss_pkg.sv
rtl/core/rss_cfg_regs.sv
rtl/core/rss_window_match.sv
rtl/core/ranged_substring_search.sv
rtl/core/rss_checker.sv
bench/ranged_substring_search_tb.sv
